// ===== hdl/retro_pad_shift_register_emulator_defines.svh =====
// ----------------------------------------------------------------------------
// Retro pad emulator assertion macros
// Shared property wrappers for the checker; every check runs on clk and
// is held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef RETRO_PAD_SHIFT_REGISTER_EMULATOR_DEFINES_SVH
`define RETRO_PAD_SHIFT_REGISTER_EMULATOR_DEFINES_SVH

// Same-cycle implication.
`define RPSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RPSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rpse_pkg.sv =====
// ----------------------------------------------------------------------------
// rpse_pkg
// Types, codes and constants shared by the retro pad emulator modules.
// ----------------------------------------------------------------------------
package rpse_pkg;

  localparam int PAD_COUNT   = 5;
  localparam int COUNT_LIMIT = 63;
  localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);
  localparam int STORE_DEPTH = PAD_COUNT * 2;
  // pads the emulation ever addresses (0..4)
  localparam int VIEW_PADS   = 5;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [7:0] MSB_MASK     = 8'h80;
  localparam logic [7:0] RESTART_MASK = 8'h40;
  localparam logic [7:0] SIG_PORT0    = 8'hEF;
  localparam logic [7:0] SIG_PORT1    = 8'hDF;
  localparam logic [3:0] LEVELS_RESET = 4'hF;
  localparam logic [CNT_W-1:0] SYNC_COUNT = CNT_W'(17);

  typedef enum logic [2:0] {
    EV_LATCH  = 3'd0,
    EV_CLK0   = 3'd1,
    EV_CLK1   = 3'd2,
    EV_SELECT = 3'd3,
    EV_WRITE  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    PM_NES2  = 3'd0,
    PM_SPLIT = 3'd1,
    PM_FOUR  = 3'd2,
    PM_SNES2 = 3'd3,
    PM_MULTI = 3'd4
  } port_mode_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [VIEW_PADS-1:0][1:0] pad_view_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       latch_level;
    logic       select_level;
    logic [2:0] pad_index;
    logic       byte_index;
    logic [7:0] byte_value;
  } item_t;

endpackage

// ===== hdl/rpse_store.sv =====
// ----------------------------------------------------------------------------
// rpse_store
// Button byte store: two bytes per pad, written by write items, read as a
// fixed per-pad view. Pads beyond the store read as zero.
// ----------------------------------------------------------------------------
module rpse_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [2:0]        wr_pad,
  input  logic              wr_byte,
  input  logic [7:0]        wr_value,
  output rpse_pkg::pad_view_t view
);
  import rpse_pkg::*;

  logic [7:0] store [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) store[i] <= '0;
    end else if (wr_en && (int'(wr_pad) < PAD_COUNT)) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (int'({wr_pad, wr_byte}) == i) store[i] <= wr_value;
      end
    end
  end

  for (genvar p = 0; p < VIEW_PADS; p++) begin : g_view
    for (genvar b = 0; b < 2; b++) begin : g_byte
      if (p < PAD_COUNT) begin : g_have
        assign view[p][b] = store[p*2 + b];
      end else begin : g_none
        assign view[p][b] = '0;
      end
    end
  end

endmodule

// ===== hdl/rpse_core.sv =====
// ----------------------------------------------------------------------------
// rpse_core
// Event engine: bit counters, shift masks, pair select and line levels.
// Computes the next line levels for one item and commits state on en.
// ----------------------------------------------------------------------------
module rpse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rpse_pkg::item_t     item,
  input  logic [2:0]          port_mode,
  input  rpse_pkg::pad_view_t view,
  output logic [3:0]          levels_next
);
  import rpse_pkg::*;

  logic [CNT_W-1:0] cnt [4];
  logic [7:0]       mask [2];
  logic             pair;
  logic [3:0]       lvl;

  logic [CNT_W-1:0] cnt_next [4];
  logic [7:0]       mask_next [2];
  logic             pair_next;

  function automatic byte_t pick(pad_view_t v, logic [2:0] pad, logic b);
    if (int'(pad) >= VIEW_PADS) return '0;
    return v[pad][b];
  endfunction

  function automatic logic hit(byte_t d, logic [7:0] mk);
    return |(d & mk);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    if (int'(c) < COUNT_LIMIT) return c + CNT_W'(1);
    return c;
  endfunction

  function automatic logic [7:0] shift(logic [7:0] mk, logic wrap);
    logic [7:0] s;
    s = mk >> 1;
    if (wrap && (s == '0)) s = MSB_MASK;
    return s;
  endfunction

  always_comb begin
    port_mode_t       m;
    logic             p;
    logic [1:0]       ci0;
    logic [1:0]       ci1;
    logic [2:0]       apad;
    logic [2:0]       bpad;
    logic [CNT_W-1:0] c;
    logic [CNT_W-4:0] idx;
    logic [7:0]       mk;
    logic             tail;

    m    = (port_mode > PM_MULTI) ? PM_NES2 : port_mode_t'(port_mode);
    p    = (item.kind == EV_CLK1);
    ci0  = {pair, 1'b0};
    ci1  = {pair, 1'b1};
    apad = item.select_level ? 3'd1 : 3'd3;
    bpad = 3'(apad + 3'd1);
    c    = '0;
    idx  = '0;
    mk   = '0;
    tail = 1'b0;

    levels_next = lvl;
    for (int i = 0; i < 4; i++) cnt_next[i] = cnt[i];
    mask_next[0] = mask[0];
    mask_next[1] = mask[1];
    pair_next    = pair;

    if (item.kind == EV_WRITE) begin
      // store handles it; levels hold
    end else if (m == PM_MULTI) begin
      tail = 1'b1;
      case (item.kind)
        EV_LATCH: begin
          if (item.latch_level) begin
            if (item.select_level) levels_next[3] = 1'b0;
          end else begin
            levels_next[2] = hit(pick(view, apad, 1'b0), MSB_MASK);
            levels_next[3] = hit(pick(view, bpad, 1'b0), MSB_MASK);
            for (int i = 0; i < 4; i++) cnt_next[i] = CNT_W'(1);
            mask_next[0] = RESTART_MASK;
            mask_next[1] = RESTART_MASK;
          end
          levels_next[0] = hit(pick(view, 3'd0, 1'b0), MSB_MASK);
        end
        EV_SELECT: begin
          if (item.select_level) begin
            pair_next = 1'b0;
          end else begin
            levels_next[2] = hit(pick(view, 3'd3, 1'b0), MSB_MASK);
            levels_next[3] = hit(pick(view, 3'd4, 1'b0), MSB_MASK);
            pair_next = 1'b1;
          end
          mask_next[0] = RESTART_MASK;
          mask_next[1] = RESTART_MASK;
        end
        EV_CLK0: begin
          if (!item.latch_level) begin
            c   = cnt[ci0];
            idx = c[CNT_W-1:3];
            levels_next[0] = (idx <= (CNT_W-3)'(1)) ?
                             hit(pick(view, 3'd0, idx[0]), mask[0]) : 1'b0;
            cnt_next[ci0] = sat_inc(c);
            mask_next[0]  = shift(mask[0], 1'b1);
          end
        end
        EV_CLK1: begin
          if (item.latch_level) begin
            levels_next[2] = hit(pick(view, 3'd1, 1'b0), MSB_MASK);
          end else begin
            c   = cnt[ci1];
            idx = c[CNT_W-1:3];
            mk  = mask[1];
            if (idx <= (CNT_W-3)'(1)) begin
              levels_next[2] = hit(pick(view, apad, idx[0]), mk);
              levels_next[3] = hit(pick(view, bpad, idx[0]), mk);
            end else if (item.select_level && (c == SYNC_COUNT)) begin
              // count seventeen: preload the MSBs of pads three and four
              levels_next[2] = hit(pick(view, 3'd3, 1'b0), MSB_MASK);
              levels_next[3] = hit(pick(view, 3'd4, 1'b0), MSB_MASK);
            end else begin
              levels_next[2] = 1'b0;
              levels_next[3] = 1'b0;
            end
            cnt_next[ci1] = sat_inc(c);
            mask_next[1]  = shift(mk, 1'b1);
          end
        end
        default: tail = 1'b0;
      endcase
      if (tail && item.latch_level && item.select_level) levels_next[3] = 1'b0;
    end else if (item.kind == EV_LATCH) begin
      if (item.latch_level || (m == PM_SNES2)) begin
        levels_next[0] = hit(pick(view, 3'd0, 1'b0), MSB_MASK);
        levels_next[2] = hit(pick(view, 3'd1, 1'b0), MSB_MASK);
        if (m == PM_SPLIT) begin
          levels_next[1] = hit(pick(view, 3'd2, 1'b0), MSB_MASK);
          levels_next[3] = hit(pick(view, 3'd3, 1'b0), MSB_MASK);
        end
        for (int i = 0; i < 4; i++) cnt_next[i] = CNT_W'(1);
        mask_next[0] = RESTART_MASK;
        mask_next[1] = RESTART_MASK;
      end
    end else if ((item.kind == EV_CLK0) || (item.kind == EV_CLK1)) begin
      c   = cnt[{1'b0, p}];
      idx = c[CNT_W-1:3];
      mk  = mask[p];
      case (m)
        PM_SPLIT: begin
          levels_next[{p, 1'b0}] = (idx == '0) ? hit(pick(view, {2'b00, p}, 1'b0), mk) : 1'b0;
          levels_next[{p, 1'b1}] = (idx == '0) ? hit(pick(view, {2'b01, p}, 1'b0), mk) : 1'b0;
        end
        PM_FOUR: begin
          if (idx == (CNT_W-3)'(0)) begin
            levels_next[{p, 1'b0}] = hit(pick(view, {2'b00, p}, 1'b0), mk);
          end else if (idx == (CNT_W-3)'(1)) begin
            levels_next[{p, 1'b0}] = hit(pick(view, {2'b01, p}, 1'b0), mk);
          end else if (idx == (CNT_W-3)'(2)) begin
            levels_next[{p, 1'b0}] = hit(p ? SIG_PORT1 : SIG_PORT0, mk);
          end else begin
            levels_next[{p, 1'b0}] = 1'b0;
          end
        end
        PM_SNES2: begin
          levels_next[{p, 1'b0}] = (idx <= (CNT_W-3)'(1)) ?
                                   hit(pick(view, {2'b00, p}, idx[0]), mk) : 1'b0;
        end
        default: begin
          levels_next[{p, 1'b0}] = (idx == '0) ? hit(pick(view, {2'b00, p}, 1'b0), mk) : 1'b0;
        end
      endcase
      cnt_next[{1'b0, p}] = sat_inc(c);
      mask_next[p] = shift(mk, (m == PM_FOUR) || (m == PM_SNES2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
      mask[0] <= MSB_MASK;
      mask[1] <= MSB_MASK;
      pair    <= 1'b0;
      lvl     <= LEVELS_RESET;
    end else if (en) begin
      for (int i = 0; i < 4; i++) cnt[i] <= cnt_next[i];
      mask[0] <= mask_next[0];
      mask[1] <= mask_next[1];
      pair    <= pair_next;
      lvl     <= levels_next;
    end
  end

endmodule

// ===== hdl/retro_pad_shift_register_emulator.sv =====
// ----------------------------------------------------------------------------
// retro_pad_shift_register_emulator
// Drives the four data lines of two console controller ports from stored
// button bytes, one line-level result per event item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event item per handshake: tuser holds the event kind
//   (latch edge, port 0 clock, port 1 clock, select edge, button write) and
//   tdata the line levels and write fields. Every item, including a button
//   write or an unknown kind, yields exactly one item on m_axis holding the
//   four line levels after the event.
//   cfg_valid/cfg_data set port_mode (0..4; 5..7 act as mode 0); cfg_ready
//   is always high. Write it only while the block is idle.
//   Path: the accepting edge loads the input register, and the result
//   register loads from it once free, raising m_axis_tvalid.
//   Throughput: one item per cycle while m_axis_tready is high, set by the
//   single event-engine stage that reads and updates the counter and mask
//   state in the same cycle.
//   Reset (rst, synchronous): both stages empty, port_mode 0, store zeroed,
//   counters 0, masks 0x80, lines high.
//   When m_axis_tready is low the result register holds; the input register
//   still takes one more item, then s_axis_tready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module retro_pad_shift_register_emulator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] latch_level, [1] select_level, [4:2] pad_index, [5] byte_index,
  // [13:6] byte_value, [15:14] zero
  input  logic [rpse_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] mode (event kind)
  input  logic [2:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] port0_d0, [1] port0_d1, [2] port1_d0, [3] port1_d1, [7:4] zero
  output logic [rpse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_data
);
  import rpse_pkg::*;

  logic [2:0] mode_reg;
  logic       s1_valid;
  item_t      s1_item;
  logic       out_free;
  logic       advance;
  logic [3:0] levels_next;
  pad_view_t  view;

  // config register; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= PM_NES2;
    end else if (cfg_valid && cfg_ready) begin
      mode_reg <= cfg_data;
    end
  end

  // result register frees when empty or being taken
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item.kind         <= s_axis_tuser;
      s1_item.latch_level  <= s_axis_tdata[0];
      s1_item.select_level <= s_axis_tdata[1];
      s1_item.pad_index    <= s_axis_tdata[4:2];
      s1_item.byte_index   <= s_axis_tdata[5];
      s1_item.byte_value   <= s_axis_tdata[13:6];
    end
  end

  rpse_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (advance && (s1_item.kind == EV_WRITE)),
    .wr_pad   (s1_item.pad_index),
    .wr_byte  (s1_item.byte_index),
    .wr_value (s1_item.byte_value),
    .view     (view)
  );

  rpse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .item        (s1_item),
    .port_mode   (mode_reg),
    .view        (view),
    .levels_next (levels_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {(OUT_TDATA_W-4)'(0), levels_next};
    end
  end

endmodule

// ===== hdl/rpse_checker.sv =====
// ----------------------------------------------------------------------------
// rpse_checker
// Port-level checks for the retro pad emulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "retro_pad_shift_register_emulator_defines.svh"

module rpse_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] cfg_data
);

  // a stalled result holds its value
  `RPSE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // pad bits of the result stay zero
  `RPSE_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[7:4] == 4'h0, "result pad bits set")

  // nothing comes out in the cycle after reset
  `RPSE_ASSERT_IMP(a_reset_empty, $past(rst), !m_axis_tvalid && s_axis_tready, "pipeline not empty after reset")

  // a result appears only if an item was offered on s_axis before it
  `RPSE_ASSERT_IMP(a_out_source, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2) || $past(s_axis_tvalid, 2), "result without input item")

endmodule

bind retro_pad_shift_register_emulator rpse_checker u_rpse_checker (.*);
